[rtl/power_hold_battery_shutdown_timer_assert.svh]
// Assertion macros shared by the shutdown timer RTL.
`ifndef POWER_HOLD_BATTERY_SHUTDOWN_TIMER_ASSERT_SVH
`define POWER_HOLD_BATTERY_SHUTDOWN_TIMER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PHBST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shutdown timer check failed");

// Consequence must hold in the cycle after the antecedent.
`define PHBST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shutdown timer check failed");

`endif

[rtl/phbst_pkg.sv]
// Types, codes and helpers for the power-hold / battery shutdown timer.
package phbst_pkg;

  localparam int TIME_W    = 32;
  localparam int PERCENT_W = 7;
  localparam int REMAIN_W  = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_RESET  = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_SAMPLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_HOLD    = 2'd1,
    CAUSE_BATTERY = 2'd2
  } cause_t;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_PERCENT  = 2'd2;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_W-1:0]    now_ms;
    logic                 button_pressed;
    logic                 sample_valid;
    logic                 sample_charging;
    logic [PERCENT_W-1:0] sample_percent;
  } item_t;

  // Post-update status handed from the state stage to the output stage.
  typedef struct packed {
    cause_t            cause;
    logic              held;
    logic              critical;
    logic              latched;
    logic [TIME_W-1:0] hold_spent;
    logic [TIME_W-1:0] elapsed;
  } status_t;

  // Time left of a duration, zero once spent, clipped to 16 bits.
  function automatic logic [REMAIN_W-1:0] time_left(logic [TIME_W-1:0] duration,
                                                    logic [TIME_W-1:0] spent);
    logic [TIME_W-1:0] d;
    d = duration - spent;
    if (spent >= duration) begin
      return '0;
    end else if (d > TIME_W'({REMAIN_W{1'b1}})) begin
      return {REMAIN_W{1'b1}};
    end else begin
      return d[REMAIN_W-1:0];
    end
  endfunction

endpackage

[rtl/phbst_core.sv]
// Event state machine: updates the supervisor state, one event per en cycle.
module phbst_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  phbst_pkg::item_t                    item,
  input  logic [phbst_pkg::TIME_W-1:0]        hold_time_ms,
  input  logic [phbst_pkg::TIME_W-1:0]        battery_limit_ms,
  input  logic [phbst_pkg::PERCENT_W-1:0]     critical_percent,
  output phbst_pkg::status_t                  status
);
  import phbst_pkg::*;
  `include "power_hold_battery_shutdown_timer_assert.svh"

  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] last_sample_time, last_sample_time_next;
  logic [TIME_W-1:0] critical_elapsed, critical_elapsed_next;
  logic button_held, button_held_next;
  logic hold_latched, hold_latched_next;
  logic critical_flag, critical_flag_next;
  logic prev_sample_critical, prev_sample_critical_next;
  logic battery_latched, battery_latched_next;
  status_t status_next;

  logic [TIME_W-1:0] spent;
  logic [TIME_W-1:0] interval;
  logic [TIME_W:0]   sum;
  logic              sample_crit;

  always_comb begin
    spent    = item.now_ms - press_time;
    interval = item.now_ms - last_sample_time;
    sum      = {1'b0, critical_elapsed} + {1'b0, interval};
    sample_crit = !item.sample_charging && (item.sample_percent < critical_percent);

    press_time_next           = press_time;
    last_sample_time_next     = last_sample_time;
    critical_elapsed_next     = critical_elapsed;
    button_held_next          = button_held;
    hold_latched_next         = hold_latched;
    critical_flag_next        = critical_flag;
    prev_sample_critical_next = prev_sample_critical;
    battery_latched_next      = battery_latched;
    status_next.cause         = CAUSE_NONE;
    status_next.hold_spent    = spent;

    case (item.mode)
      MODE_RESET: begin
        press_time_next           = item.now_ms;
        last_sample_time_next     = item.now_ms;
        critical_elapsed_next     = '0;
        button_held_next          = 1'b0;
        hold_latched_next         = 1'b0;
        critical_flag_next        = 1'b0;
        prev_sample_critical_next = 1'b0;
        battery_latched_next      = 1'b0;
      end
      MODE_BUTTON: begin
        if (item.button_pressed != button_held) begin
          button_held_next  = item.button_pressed;
          hold_latched_next = 1'b0;
          if (item.button_pressed) begin
            press_time_next        = item.now_ms;
            status_next.hold_spent = '0;
          end
        end
      end
      MODE_TICK: begin
        if (button_held && !hold_latched && spent >= hold_time_ms) begin
          hold_latched_next = 1'b1;
          status_next.cause = CAUSE_HOLD;
        end
      end
      MODE_SAMPLE: begin
        last_sample_time_next = item.now_ms;
        if (item.sample_valid && !sample_crit) begin
          critical_elapsed_next     = '0;
          critical_flag_next        = 1'b0;
          prev_sample_critical_next = 1'b0;
          battery_latched_next      = 1'b0;
        end else if (item.sample_valid) begin
          critical_flag_next        = 1'b1;
          prev_sample_critical_next = 1'b1;
          if (prev_sample_critical) begin
            // clamp to the limit; the sum never wraps
            critical_elapsed_next = (sum > {1'b0, battery_limit_ms}) ?
                                    battery_limit_ms : sum[TIME_W-1:0];
          end
          if (!battery_latched && critical_elapsed_next >= battery_limit_ms) begin
            battery_latched_next = 1'b1;
            status_next.cause    = CAUSE_BATTERY;
          end
        end
      end
      default: begin
      end
    endcase

    status_next.held     = button_held_next;
    status_next.critical = critical_flag_next;
    status_next.latched  = hold_latched_next || battery_latched_next;
    status_next.elapsed  = critical_elapsed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_time           <= '0;
      last_sample_time     <= '0;
      critical_elapsed     <= '0;
      button_held          <= 1'b0;
      hold_latched         <= 1'b0;
      critical_flag        <= 1'b0;
      prev_sample_critical <= 1'b0;
      battery_latched      <= 1'b0;
    end else if (en) begin
      press_time           <= press_time_next;
      last_sample_time     <= last_sample_time_next;
      critical_elapsed     <= critical_elapsed_next;
      button_held          <= button_held_next;
      hold_latched         <= hold_latched_next;
      critical_flag        <= critical_flag_next;
      prev_sample_critical <= prev_sample_critical_next;
      battery_latched      <= battery_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= status_next;
    end
  end

  `PHBST_ASSERT_NOW(a_batt_latch_needs_crit, battery_latched, critical_flag)
  `PHBST_ASSERT_NOW(a_elapsed_needs_prev, critical_elapsed != '0, prev_sample_critical)
  `PHBST_ASSERT_NEXT(a_hold_cause_latches, en && status_next.cause == CAUSE_HOLD,
                     hold_latched && button_held)

endmodule

[rtl/power_hold_battery_shutdown_timer.sv]
// Top level of the power-hold / battery shutdown timer.
//
// Input beats (s_*) carry one event each: the event kind in s_tuser and the
// timestamp and sample fields in s_tdata. Every event yields exactly one
// result beat on m_*, reporting the shutdown cause raised by that event and
// the supervisor state after it, with both remaining times clipped to 16 bits.
// User writes registers via cfg_we/cfg_index/cfg_wdata only while idle; unchecked.
//
// Three register stages: input register, state update, output register.
// Each accepted input beat passes through them in turn to its result beat; one
// event is taken every cycle while the output moves. The state update stage
// sets the rate: each event reads the state left by the one before.
//
// rst (synchronous) clears all stage valids, the event state and returns the
// registers to their defaults (hold 3000 ms, limit 60000 ms, 5 percent).
// When m_tready is low, hold the result; earlier stages keep filling until
// every stage is full, then s_tready drops. No beat is lost or repeated.
module power_hold_battery_shutdown_timer (
  input  logic        clk,
  input  logic        rst,
  // event kind: mode[1:0]
  input  logic [1:0]  s_tuser,
  // now_ms[31:0], button_pressed[32], sample_valid[33], sample_charging[34],
  // sample_percent[41:35], zero pad[47:42]
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // shutdown_cause[1:0], held_now[2], battery_critical[3], any_latched[4],
  // hold_remaining_ms[20:5], battery_remaining_ms[36:21], zero pad[39:37]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import phbst_pkg::*;
  `include "power_hold_battery_shutdown_timer_assert.svh"

  // configuration registers
  logic [TIME_W-1:0]    hold_time_ms;
  logic [TIME_W-1:0]    battery_limit_ms;
  logic [PERCENT_W-1:0] critical_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms     <= TIME_W'(3000);
      battery_limit_ms <= TIME_W'(60000);
      critical_percent <= PERCENT_W'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_TIME:     hold_time_ms     <= cfg_wdata;
        REG_BATTERY_LIMIT: battery_limit_ms <= cfg_wdata;
        REG_CRIT_PERCENT:  critical_percent <= cfg_wdata[PERCENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline valids and advance strobes
  logic    in_valid, st_valid;
  logic    out_load, st_load, in_load;
  item_t   in_item;
  status_t status;

  assign out_load = st_valid && (!m_tvalid || m_tready);
  assign st_load  = in_valid && (!st_valid || out_load);
  assign s_tready = !in_valid || st_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (st_load) begin
        in_valid <= 1'b0;
      end
      if (st_load) begin
        st_valid <= 1'b1;
      end else if (out_load) begin
        st_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item.mode            <= mode_t'(s_tuser);
      in_item.now_ms          <= s_tdata[31:0];
      in_item.button_pressed  <= s_tdata[32];
      in_item.sample_valid    <= s_tdata[33];
      in_item.sample_charging <= s_tdata[34];
      in_item.sample_percent  <= s_tdata[41:35];
    end
  end

  phbst_core u_core (
    .clk              (clk),
    .rst              (rst),
    .en               (st_load),
    .item             (in_item),
    .hold_time_ms     (hold_time_ms),
    .battery_limit_ms (battery_limit_ms),
    .critical_percent (critical_percent),
    .status           (status)
  );

  // remaining times and result packing
  logic [REMAIN_W-1:0] hold_rem, batt_rem;

  always_comb begin
    hold_rem = status.held ? time_left(hold_time_ms, status.hold_spent) : '0;
    batt_rem = status.critical ? time_left(battery_limit_ms, status.elapsed) : '0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, batt_rem, hold_rem, status.latched, status.critical,
                  status.held, status.cause};
    end
  end

  `PHBST_ASSERT_NOW(a_stall_only_on_full, !s_tready, m_tvalid && !m_tready && st_valid)
  `PHBST_ASSERT_NOW(a_cause_means_latched, m_tvalid && m_tdata[1:0] != CAUSE_NONE,
                    m_tdata[4])
  `PHBST_ASSERT_NOW(a_hold_rem_needs_held, m_tvalid && m_tdata[20:5] != '0, m_tdata[2])

endmodule
